FILE: sv/hse_pkg.sv
`timescale 1ns / 1ps
package hse_pkg;

    localparam int MAX_KNOTS = 64;
    localparam int KNOT_AW   = $clog2(MAX_KNOTS);
    localparam int FRAC_BITS = 16;
    localparam int S_BITS    = 30;
    localparam int KC_W      = 7;
    localparam int TOL_W     = 16;
    localparam int T_W       = 32;
    localparam int V_W       = 32;
    localparam int IDX_W     = 6;
    localparam int OP_W      = 34;
    localparam int PROD_W    = 2 * OP_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int DATA_W    = 2 * V_W + 1;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;

    localparam logic REG_KNOT_COUNT = 1'b0;
    localparam logic REG_SNAP_TOL   = 1'b1;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STAT_VALID   = 2'd0,
        STAT_WRITTEN = 2'd1,
        STAT_EARLY   = 2'd2,
        STAT_LATE    = 2'd3
    } status_t;

    typedef struct packed {
        action_t           action;
        logic [IDX_W-1:0]  knot_index;
        logic [T_W-1:0]    knot_time;
        logic [V_W-1:0]    knot_position;
        logic [V_W-1:0]    knot_velocity;
        logic              has_velocity;
        logic [T_W-1:0]    query_time;
    } hse_item_t;

endpackage

FILE: sv/hse_ram.sv
`timescale 1ns / 1ps
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/hse_front.sv
`timescale 1ns / 1ps
module hse_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hse_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hse_pkg::hse_item_t           out_item
);
    import hse_pkg::*;

    hse_item_t  fifo_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    hse_item_t  item_in;
    logic       push, pop;

    // Field layout on tdata from bit 0 up: index, time, position, velocity, flag, query.
    always_comb begin
        item_in.action        = action_t'(s_tuser);
        item_in.knot_index    = s_tdata[5:0];
        item_in.knot_time     = s_tdata[37:6];
        item_in.knot_position = s_tdata[69:38];
        item_in.knot_velocity = s_tdata[101:70];
        item_in.has_velocity  = s_tdata[102];
        item_in.query_time    = s_tdata[134:103];
    end

    assign s_tready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = fifo_reg[rptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                fifo_reg[wptr_reg] <= item_in;
                wptr_reg           <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: sv/hse_back.sv
`timescale 1ns / 1ps
module hse_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hse_pkg::hse_item_t            in_item,
    input  logic [hse_pkg::KC_W-1:0]      knot_count,
    input  logic [hse_pkg::TOL_W-1:0]     snap_tol,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hse_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser
);
    import hse_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_WR    = 14'b00000000000010,
        S_T0    = 14'b00000000000100,
        S_TL    = 14'b00000000001000,
        S_CHK   = 14'b00000000010000,
        S_SRCH  = 14'b00000000100000,
        S_RDA   = 14'b00000001000000,
        S_RDB   = 14'b00000010000000,
        S_PREP  = 14'b00000100000000,
        S_DIV   = 14'b00001000000000,
        S_MLOAD = 14'b00010000000000,
        S_MWAIT = 14'b00100000000000,
        S_MUSE  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    localparam logic [S_BITS:0]   S_ONE   = (S_BITS + 1)'(1) << S_BITS;
    localparam logic [OP_W-1:0]   S_ONE_E = OP_W'(1) << S_BITS;

    state_t              state_reg;
    hse_item_t           item_reg;
    logic [T_W-1:0]      q_reg, t0_reg, tl_reg, tprev_reg, ta_reg, tb_reg, d_reg, rem_reg;
    logic [KNOT_AW-1:0]  i_reg, found_reg;
    logic signed [V_W-1:0] pa_reg, pb_reg, va_reg, vb_reg;
    logic [S_BITS:0]     s_reg, s2_reg, s3_reg;
    logic [4:0]          cnt_reg;
    logic [2:0]          mstep_reg;
    logic signed [OP_W-1:0]   op_a_reg, op_b_reg, p_reg, w_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [V_W-1:0]      res_value_reg;
    logic [IDX_W-1:0]    res_seg_reg;
    status_t             res_stat_reg;
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    status_t             m_stat_reg;

    logic [KC_W-1:0]     n_eff;
    logic [KNOT_AW-1:0]  nm1;
    logic [T_W-1:0]      t_rdata, q_snap, tau, dd;
    logic [KNOT_AW-1:0]  t_raddr, d_raddr;
    logic [DATA_W-1:0]   d_rdata;
    logic                early_fail, t_we;
    logic [T_W:0]        rem2;
    logic                ge;
    logic signed [OP_W-1:0]   s_e, s2_e, s3_e, h00, h01, h10, h11, op_a_sel, op_b_sel;
    logic signed [ACC_W-1:0]  prod_e, acc_sum;
    logic signed [PROD_W-1:0] rw_sum;
    logic signed [PROD_W-FRAC_BITS:0] v_sum;

    // Effective knot count is clamped into the supported range.
    always_comb begin
        if (knot_count < KC_W'(2)) begin
            n_eff = KC_W'(2);
        end else if (knot_count > KC_W'(MAX_KNOTS)) begin
            n_eff = KC_W'(MAX_KNOTS);
        end else begin
            n_eff = knot_count;
        end
        nm1 = KNOT_AW'(n_eff - KC_W'(1));
    end

    assign in_ready = (state_reg == S_IDLE);
    assign t_we = (state_reg == S_WR) &&
                  ({1'b0, item_reg.knot_index} < KC_W'(MAX_KNOTS));

    always_comb begin
        priority if (state_reg == S_TL) begin
            t_raddr = nm1;
        end else if (state_reg == S_CHK) begin
            t_raddr = KNOT_AW'(1);
        end else if (state_reg == S_SRCH) begin
            t_raddr = i_reg + KNOT_AW'(1);
        end else begin
            t_raddr = '0;
        end
        d_raddr = (state_reg == S_RDA) ? found_reg - KNOT_AW'(1) : found_reg;
    end

    hse_ram #(.WIDTH(T_W), .DEPTH(MAX_KNOTS)) u_time_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (KNOT_AW'(item_reg.knot_index)),
        .wdata (item_reg.knot_time),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    hse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_data_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (KNOT_AW'(item_reg.knot_index)),
        .wdata ({item_reg.has_velocity, item_reg.knot_velocity, item_reg.knot_position}),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // Snap onto the table ends; t_rdata holds the last knot time in S_CHK.
    always_comb begin
        logic [T_W-1:0] q0;
        q0 = item_reg.query_time;
        early_fail = 1'b0;
        q_snap = q0;
        if (q0 < t0_reg) begin
            if ((t0_reg - q0) < T_W'(snap_tol)) begin
                q_snap = t0_reg;
            end else begin
                early_fail = 1'b1;
            end
        end
        if ((q_snap > t_rdata) && ((q_snap - t_rdata) < T_W'(snap_tol))) begin
            q_snap = t_rdata;
        end
    end

    always_comb begin
        tau  = (q_reg >= ta_reg) ? q_reg - ta_reg : '0;
        dd   = (tb_reg > ta_reg) ? tb_reg - ta_reg : '0;
        rem2 = {rem_reg, 1'b0};
        ge   = (rem2 >= {1'b0, d_reg});
    end

    // Hermite basis from s, s^2 and s^3 (Q1.30), widened to signed values with 30 fraction bits.
    always_comb begin
        s_e  = OP_W'(s_reg);
        s2_e = OP_W'(s2_reg);
        s3_e = OP_W'(s3_reg);
        h00  = 2 * s3_e - 3 * s2_e + S_ONE_E;
        h01  = S_ONE_E - h00;
        h10  = s3_e - 2 * s2_e + s_e;
        h11  = s3_e - s2_e;
        unique case (mstep_reg)
            3'd0: begin op_a_sel = s_e;  op_b_sel = s_e; end
            3'd1: begin op_a_sel = s2_e; op_b_sel = s_e; end
            3'd2: begin op_a_sel = OP_W'(pa_reg); op_b_sel = h00; end
            3'd3: begin op_a_sel = OP_W'(pb_reg); op_b_sel = h01; end
            3'd4: begin op_a_sel = OP_W'(va_reg); op_b_sel = h10; end
            3'd5: begin op_a_sel = OP_W'(vb_reg); op_b_sel = h11; end
            3'd6: begin op_a_sel = w_reg; op_b_sel = OP_W'(d_reg); end
            default: begin op_a_sel = '0; op_b_sel = '0; end
        endcase
        prod_e  = ACC_W'(prod_reg);
        acc_sum = acc_reg + prod_e + (ACC_W'(1) <<< (S_BITS - 1));
        rw_sum  = prod_reg + (PROD_W'(1) <<< (FRAC_BITS - 1));
        v_sum   = (PROD_W - FRAC_BITS + 1)'(p_reg) +
                  (PROD_W - FRAC_BITS + 1)'(rw_sum >>> FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a_reg * op_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // S_OUT decides the valid flag itself when it loads a new result.
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        item_reg  <= in_item;
                        state_reg <= (in_item.action == ACT_WRITE) ? S_WR : S_T0;
                    end
                end
                S_WR: begin
                    res_value_reg <= '0;
                    res_seg_reg   <= item_reg.knot_index;
                    res_stat_reg  <= STAT_WRITTEN;
                    state_reg     <= S_OUT;
                end
                S_T0: state_reg <= S_TL;
                S_TL: begin
                    t0_reg    <= t_rdata;
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    tl_reg    <= t_rdata;
                    tprev_reg <= t0_reg;
                    i_reg     <= KNOT_AW'(1);
                    q_reg     <= q_snap;
                    if (early_fail) begin
                        res_value_reg <= '0;
                        res_seg_reg   <= '0;
                        res_stat_reg  <= STAT_EARLY;
                        state_reg     <= S_OUT;
                    end else begin
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (q_reg < t_rdata) begin
                        found_reg <= i_reg;
                        ta_reg    <= tprev_reg;
                        tb_reg    <= t_rdata;
                        state_reg <= S_RDA;
                    end else if (i_reg == nm1) begin
                        if (q_reg == tl_reg) begin
                            found_reg <= nm1;
                            ta_reg    <= tprev_reg;
                            tb_reg    <= t_rdata;
                            state_reg <= S_RDA;
                        end else begin
                            res_value_reg <= '0;
                            res_seg_reg   <= '0;
                            res_stat_reg  <= STAT_LATE;
                            state_reg     <= S_OUT;
                        end
                    end else begin
                        tprev_reg <= t_rdata;
                        i_reg     <= i_reg + KNOT_AW'(1);
                    end
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB: begin
                    pa_reg    <= d_rdata[V_W-1:0];
                    va_reg    <= d_rdata[DATA_W-1] ? d_rdata[2*V_W-1:V_W] : '0;
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    pb_reg    <= d_rdata[V_W-1:0];
                    vb_reg    <= d_rdata[DATA_W-1] ? d_rdata[2*V_W-1:V_W] : '0;
                    mstep_reg <= '0;
                    cnt_reg   <= '0;
                    // A degenerate or overrun segment evaluates to its end position.
                    if ((dd == '0) || (tau >= dd)) begin
                        s_reg     <= S_ONE;
                        d_reg     <= '0;
                        state_reg <= S_MLOAD;
                    end else begin
                        s_reg     <= '0;
                        rem_reg   <= tau;
                        d_reg     <= dd;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= ge ? T_W'(rem2 - {1'b0, d_reg}) : rem2[T_W-1:0];
                    s_reg   <= {s_reg[S_BITS-1:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(S_BITS - 1)) begin
                        state_reg <= S_MLOAD;
                    end
                end
                S_MLOAD: begin
                    op_a_reg  <= op_a_sel;
                    op_b_reg  <= op_b_sel;
                    state_reg <= S_MWAIT;
                end
                S_MWAIT: state_reg <= S_MUSE;
                S_MUSE: begin
                    mstep_reg <= mstep_reg + 3'd1;
                    unique case (mstep_reg)
                        3'd0: begin
                            s2_reg    <= prod_reg[2*S_BITS:S_BITS];
                            state_reg <= S_MLOAD;
                        end
                        3'd1: begin
                            s3_reg    <= prod_reg[2*S_BITS:S_BITS];
                            state_reg <= S_MLOAD;
                        end
                        3'd2: begin
                            acc_reg   <= prod_e;
                            state_reg <= S_MLOAD;
                        end
                        3'd3: begin
                            p_reg     <= acc_sum[S_BITS+OP_W-1:S_BITS];
                            state_reg <= S_MLOAD;
                        end
                        3'd4: begin
                            acc_reg   <= prod_e;
                            state_reg <= S_MLOAD;
                        end
                        3'd5: begin
                            w_reg     <= acc_sum[S_BITS+OP_W-1:S_BITS];
                            state_reg <= S_MLOAD;
                        end
                        3'd6: begin
                            res_seg_reg  <= IDX_W'(found_reg);
                            res_stat_reg <= STAT_VALID;
                            state_reg    <= S_OUT;
                            if (v_sum > (PROD_W - FRAC_BITS + 1)'(32'sh7FFFFFFF)) begin
                                res_value_reg <= 32'h7FFFFFFF;
                            end else if (v_sum < -(PROD_W - FRAC_BITS + 1)'(33'sh080000000))
                            begin
                                res_value_reg <= 32'h80000000;
                            end else begin
                                res_value_reg <= v_sum[V_W-1:0];
                            end
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, res_seg_reg, res_value_reg};
                        m_stat_reg  <= res_stat_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stat_reg;
endmodule

FILE: sv/hermite_spline_evaluator_top.sv
// A knot write returns a WRITTEN status result; a query runs a linear search with
// one table read per knot in use, a restoring division over the 30 fraction bits
// of s, and seven products on one shared multiplier.
// A new item starts only after the last is done; a two-entry input queue takes items meanwhile.
// Reset (aresetn low, synchronous) empties the queue and the output, and sets
// knot_count to 2 and snap_tolerance to 66; the knot table is undefined until written.
`timescale 1ns / 1ps
module hermite_spline_evaluator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // index[5:0], time[37:6], position[69:38], velocity[101:70], has_velocity[102],
    // query_time[134:103], zero fill above
    input  logic [hse_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,   // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hse_pkg::M_TDATA_W-1:0] m_tdata,   // value[31:0], segment_index[37:32]
    output logic [1:0]                    m_tuser,   // status
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import hse_pkg::*;

    logic [KC_W-1:0]  knot_count_reg;
    logic [TOL_W-1:0] snap_tol_reg;
    logic             fe_valid, fe_ready;
    hse_item_t        fe_item;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knot_count_reg <= KC_W'(2);
            snap_tol_reg   <= TOL_W'(66);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_KNOT_COUNT) begin
                knot_count_reg <= pwdata[KC_W-1:0];
            end else begin
                snap_tol_reg <= pwdata[TOL_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SNAP_TOL) ? 32'(snap_tol_reg) : 32'(knot_count_reg);

    hse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_item  (fe_item)
    );

    hse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fe_valid),
        .in_ready   (fe_ready),
        .in_item    (fe_item),
        .knot_count (knot_count_reg),
        .snap_tol   (snap_tol_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );
endmodule

FILE: sv/hse_checker.sv
`timescale 1ns / 1ps
module hse_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hse_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);
    import hse_pkg::*;

    // No result may be offered right after a reset cycle.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Out-of-range queries carry neither a value nor a segment.
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_EARLY || m_tuser == STAT_LATE) |-> m_tdata == '0)
        else $error("range error result carries data");

    // A knot write reports a zero value.
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_WRITTEN |-> m_tdata[31:0] == '0)
        else $error("write result carries a value");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
endmodule

bind hermite_spline_evaluator_top hse_checker u_hse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
